// File: design/ycc_pkg.sv
// ycc_pkg: shared widths, register map, reset values and stage types
// for the ycbcr_to_rgb_q20 pixel converter. No dependencies.
`default_nettype none

package ycc_pkg;

  localparam int SAMPLE_W = 12;             // width of each input sample field
  localparam int DIFF_W   = SAMPLE_W + 1;   // signed sample minus offset
  localparam int MODE_W   = 2;
  localparam int GAIN_W   = 21;
  localparam int COEF_W   = 23;             // signed Q20 coefficient, gain fits too
  localparam int PROD_W   = DIFF_W + COEF_W;
  localparam int SUM_W    = PROD_W + 2;     // room for three terms
  localparam int FRAC_W   = 20;
  localparam int PIX_W    = 8;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 5;
  localparam int REG_IDX_W = 3;

  localparam logic signed [SUM_W-1:0] HALF_Q20 = SUM_W'(64'sd1 <<< (FRAC_W - 1));

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_BLACK_LEVEL = 3'd1,
    REG_CHROMA_MID  = 3'd2,
    REG_LUMA_GAIN   = 3'd3,
    REG_CR_TO_RED   = 3'd4,
    REG_CB_TO_BLUE  = 3'd5,
    REG_CB_TO_GREEN = 3'd6,
    REG_CR_TO_GREEN = 3'd7
  } reg_idx_t;

  localparam logic [MODE_W-1:0]   MODE_RST        = 2'd0;
  localparam logic [SAMPLE_W-1:0] BLACK_LEVEL_RST = 12'd16;
  localparam logic [SAMPLE_W-1:0] CHROMA_MID_RST  = 12'd128;
  localparam logic [GAIN_W-1:0]   LUMA_GAIN_RST   = 21'd1220997;
  localparam logic signed [COEF_W-1:0] CR_TO_RED_RST   = 23'sd1673527;
  localparam logic signed [COEF_W-1:0] CB_TO_BLUE_RST  = 23'sd2114978;
  localparam logic signed [COEF_W-1:0] CB_TO_GREEN_RST = -23'sd410793;
  localparam logic signed [COEF_W-1:0] CR_TO_GREEN_RST = -23'sd852492;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SAMPLE_W-1:0] black_level;
    logic [SAMPLE_W-1:0] chroma_mid;
    logic [GAIN_W-1:0]   luma_gain;
    logic [COEF_W-1:0]   cr_to_red;
    logic [COEF_W-1:0]   cb_to_blue;
    logic [COEF_W-1:0]   cb_to_green;
    logic [COEF_W-1:0]   cr_to_green;
  } cfg_t;

  typedef struct packed {
    logic mono;
    logic ident;
  } mode_flags_t;

  // after offset removal
  typedef struct packed {
    mode_flags_t       flags;
    logic [DIFF_W-1:0] y_d;
    logic [DIFF_W-1:0] b_op;
    logic [DIFF_W-1:0] r_op;
  } ofs_t;

  // after the multipliers
  typedef struct packed {
    mode_flags_t       flags;
    logic [PROD_W-1:0] p_y;
    logic [PROD_W-1:0] p_r;
    logic [PROD_W-1:0] p_b;
    logic [PROD_W-1:0] p_bg;
    logic [PROD_W-1:0] p_rg;
  } prod_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

// File: design/ycc_cfg_regs.sv
// ycc_cfg_regs: APB register file holding mode, offsets, gain and Q20 coefficients.
// Depends on ycc_pkg.
`default_nettype none

module ycc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ycc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [ycc_pkg::APB_DW-1:0]  pwdata,
  output logic      [ycc_pkg::APB_DW-1:0]  prdata,
  output logic                             pready,
  output ycc_pkg::cfg_t                    cfg
);
  import ycc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MODE:        cfg_nxt.mode        = pwdata[MODE_W-1:0];
        REG_BLACK_LEVEL: cfg_nxt.black_level = pwdata[SAMPLE_W-1:0];
        REG_CHROMA_MID:  cfg_nxt.chroma_mid  = pwdata[SAMPLE_W-1:0];
        REG_LUMA_GAIN:   cfg_nxt.luma_gain   = pwdata[GAIN_W-1:0];
        REG_CR_TO_RED:   cfg_nxt.cr_to_red   = pwdata[COEF_W-1:0];
        REG_CB_TO_BLUE:  cfg_nxt.cb_to_blue  = pwdata[COEF_W-1:0];
        REG_CB_TO_GREEN: cfg_nxt.cb_to_green = pwdata[COEF_W-1:0];
        REG_CR_TO_GREEN: cfg_nxt.cr_to_green = pwdata[COEF_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_RST;
      cfg_r.black_level <= BLACK_LEVEL_RST;
      cfg_r.chroma_mid  <= CHROMA_MID_RST;
      cfg_r.luma_gain   <= LUMA_GAIN_RST;
      cfg_r.cr_to_red   <= CR_TO_RED_RST;
      cfg_r.cb_to_blue  <= CB_TO_BLUE_RST;
      cfg_r.cb_to_green <= CB_TO_GREEN_RST;
      cfg_r.cr_to_green <= CR_TO_GREEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // signed coefficients read back sign-extended
  always_comb begin
    unique case (idx)
      REG_MODE:        prdata = APB_DW'(cfg_r.mode);
      REG_BLACK_LEVEL: prdata = APB_DW'(cfg_r.black_level);
      REG_CHROMA_MID:  prdata = APB_DW'(cfg_r.chroma_mid);
      REG_LUMA_GAIN:   prdata = APB_DW'(cfg_r.luma_gain);
      REG_CR_TO_RED:   prdata = APB_DW'($signed(cfg_r.cr_to_red));
      REG_CB_TO_BLUE:  prdata = APB_DW'($signed(cfg_r.cb_to_blue));
      REG_CB_TO_GREEN: prdata = APB_DW'($signed(cfg_r.cb_to_green));
      REG_CR_TO_GREEN: prdata = APB_DW'($signed(cfg_r.cr_to_green));
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: design/ycc_offset.sv
// ycc_offset: stage 1, masks samples and removes black level / chroma midpoint.
// Depends on ycc_pkg.
`default_nettype none

module ycc_offset #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire logic [ycc_pkg::SAMPLE_W-1:0]  luma,
  input  wire logic [ycc_pkg::SAMPLE_W-1:0]  cb,
  input  wire logic [ycc_pkg::SAMPLE_W-1:0]  cr,
  input  ycc_pkg::cfg_t                      cfg,
  output logic                               out_vld,
  output ycc_pkg::ofs_t                      out_data
);
  import ycc_pkg::*;

  localparam int USE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((64'd1 << USE_BITS) - 64'd1);

  logic [SAMPLE_W-1:0] y_m, cb_m, cr_m;
  logic [DIFF_W-1:0]   blk_e, mid_e, cb_sub, cr_sub;
  ofs_t                data_nxt;
  ofs_t                data_r;
  logic                vld_r;

  always_comb begin
    y_m  = luma & SMASK;
    cb_m = cb & SMASK;
    cr_m = cr & SMASK;
    data_nxt.flags.mono  = cfg.mode[1];
    data_nxt.flags.ident = ~cfg.mode[1] & cfg.mode[0];
    blk_e = {1'b0, cfg.black_level};
    mid_e = {1'b0, cfg.chroma_mid};
    // identity mode scales the chroma planes like luma
    cb_sub = data_nxt.flags.ident ? blk_e : mid_e;
    cr_sub = data_nxt.flags.ident ? blk_e : mid_e;
    data_nxt.y_d  = {1'b0, y_m}  - blk_e;
    data_nxt.b_op = {1'b0, cb_m} - cb_sub;
    data_nxt.r_op = {1'b0, cr_m} - cr_sub;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

`default_nettype wire

// File: design/ycc_mult.sv
// ycc_mult: stage 2, five parallel 13x23 signed multipliers.
// Depends on ycc_pkg.
`default_nettype none

module ycc_mult (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_vld,
  input  ycc_pkg::ofs_t in_data,
  input  ycc_pkg::cfg_t cfg,
  output logic          out_vld,
  output ycc_pkg::prod_t out_data
);
  import ycc_pkg::*;

  logic signed [COEF_W-1:0] gain_s, coef_r, coef_b;
  logic signed [PROD_W-1:0] p_y, p_r, p_b, p_bg, p_rg;
  prod_t                    data_r;
  logic                     vld_r;

  always_comb begin
    gain_s = $signed({2'b00, cfg.luma_gain});
    coef_r = in_data.flags.ident ? gain_s : $signed(cfg.cr_to_red);
    coef_b = in_data.flags.ident ? gain_s : $signed(cfg.cb_to_blue);
    p_y  = $signed(in_data.y_d)  * gain_s;
    p_r  = $signed(in_data.r_op) * coef_r;
    p_b  = $signed(in_data.b_op) * coef_b;
    p_bg = $signed(in_data.b_op) * $signed(cfg.cb_to_green);
    p_rg = $signed(in_data.r_op) * $signed(cfg.cr_to_green);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r.flags <= in_data.flags;
    data_r.p_y   <= p_y;
    data_r.p_r   <= p_r;
    data_r.p_b   <= p_b;
    data_r.p_bg  <= p_bg;
    data_r.p_rg  <= p_rg;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

`default_nettype wire

// File: design/ycc_sum_clip.sv
// ycc_sum_clip: stages 3 and 4, mode select, Q20 rounding sums, shift and clamp.
// Depends on ycc_pkg.
`default_nettype none

module ycc_sum_clip (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_vld,
  input  ycc_pkg::prod_t in_data,
  output logic           out_vld,
  output ycc_pkg::rgb_t  out_data
);
  import ycc_pkg::*;

  logic signed [SUM_W-1:0] p_y, p_r, p_b, p_bg, p_rg;
  logic signed [SUM_W-1:0] r_nxt, g_nxt, b_nxt;
  logic signed [SUM_W-1:0] r_r, g_r, b_r;
  logic                    vld1_r, vld2_r;
  rgb_t                    rgb_nxt, rgb_r;

  function automatic logic [PIX_W-1:0] clamp_pix(input logic [SUM_W-1:0] v);
    logic over;
    over = |v[SUM_W-2:FRAC_W+PIX_W];
    if (v[SUM_W-1])
      clamp_pix = '0;
    else if (over)
      clamp_pix = '1;
    else
      clamp_pix = v[FRAC_W+PIX_W-1:FRAC_W];
  endfunction

  always_comb begin
    p_y  = SUM_W'($signed(in_data.p_y));
    p_r  = SUM_W'($signed(in_data.p_r));
    p_b  = SUM_W'($signed(in_data.p_b));
    p_bg = SUM_W'($signed(in_data.p_bg));
    p_rg = SUM_W'($signed(in_data.p_rg));
    if (in_data.flags.mono) begin
      r_nxt = p_y + HALF_Q20;
      g_nxt = p_y + HALF_Q20;
      b_nxt = p_y + HALF_Q20;
    end else if (in_data.flags.ident) begin
      r_nxt = p_r + HALF_Q20;
      g_nxt = p_y + HALF_Q20;
      b_nxt = p_b + HALF_Q20;
    end else begin
      r_nxt = p_y + p_r + HALF_Q20;
      g_nxt = p_y + p_bg + p_rg + HALF_Q20;
      b_nxt = p_y + p_b + HALF_Q20;
    end
  end

  always_comb begin
    rgb_nxt.red   = clamp_pix(r_r);
    rgb_nxt.green = clamp_pix(g_r);
    rgb_nxt.blue  = clamp_pix(b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    g_r   <= g_nxt;
    b_r   <= b_nxt;
    rgb_r <= rgb_nxt;
  end

  assign out_vld  = vld2_r;
  assign out_data = rgb_r;

endmodule

`default_nettype wire

// File: design/ycbcr_to_rgb_q20.sv
// ycbcr_to_rgb_q20: top level of the YCbCr to 8-bit RGB pixel converter.
// Depends on ycc_pkg, ycc_cfg_regs, ycc_offset, ycc_mult, ycc_sum_clip.
//
// Usage:
//   Input: a pixel beat (luma, blue and red chroma) is taken at each rising
//   edge with start high and busy low. busy is never raised, so one pixel
//   can enter every clock.
//   Output: out_valid marks one result beat (red, green, blue) for one
//   cycle; the receiver cannot stall, so no back-pressure exists.
//   Throughput is 1 pixel per clock. Each pixel passes through the four
//   register stages in order: offset removal, the five multipliers, the
//   rounding sums, and the shift/clamp.
//   Configuration: APB-style port, register i at byte address 4*i, writes
//   complete in the access cycle, pready always high. Change registers only
//   while no pixel is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register defaults (BT.601 limited range, colour-difference mode).
`default_nettype none

module ycbcr_to_rgb_q20 #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ycc_pkg::SAMPLE_W-1:0] in_luma_sample,
  input  wire logic [ycc_pkg::SAMPLE_W-1:0] in_blue_chroma,
  input  wire logic [ycc_pkg::SAMPLE_W-1:0] in_red_chroma,
  output logic                              out_valid,
  output logic      [ycc_pkg::PIX_W-1:0]    out_red,
  output logic      [ycc_pkg::PIX_W-1:0]    out_green,
  output logic      [ycc_pkg::PIX_W-1:0]    out_blue,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ycc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [ycc_pkg::APB_DW-1:0]   pwdata,
  output logic      [ycc_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);
  import ycc_pkg::*;

  cfg_t  cfg;
  logic  ofs_vld, prod_vld, rgb_vld;
  ofs_t  ofs_data;
  prod_t prod_data;
  rgb_t  rgb_data;
  logic  accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  ycc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ycc_offset #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_offset (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .luma     (in_luma_sample),
    .cb       (in_blue_chroma),
    .cr       (in_red_chroma),
    .cfg      (cfg),
    .out_vld  (ofs_vld),
    .out_data (ofs_data)
  );

  ycc_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (ofs_vld),
    .in_data  (ofs_data),
    .cfg      (cfg),
    .out_vld  (prod_vld),
    .out_data (prod_data)
  );

  ycc_sum_clip u_sum_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (prod_vld),
    .in_data  (prod_data),
    .out_vld  (rgb_vld),
    .out_data (rgb_data)
  );

  assign out_valid = rgb_vld;
  assign out_red   = rgb_data.red;
  assign out_green = rgb_data.green;
  assign out_blue  = rgb_data.blue;

endmodule

`default_nettype wire
